// ===== sv/brq_pkg.sv =====
package brq_pkg;

   localparam int CNT_W = 11;

   // Operation codes of an input word.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_BYTE   = 2'd1;
   localparam logic [1:0] KIND_COUNT  = 2'd2;

   // Write block status codes.
   localparam logic [1:0] WS_OK        = 2'd0;
   localparam logic [1:0] WS_OVERFLOW  = 2'd1;
   localparam logic [1:0] WS_TOO_LARGE = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  data_byte;
      logic        block_first;
      logic [10:0] block_length;
      logic [6:0]  read_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [1:0]  write_status;
      logic [7:0]  read_byte;
      logic        byte_valid;
      logic        last;
      logic [10:0] used_count;
   } rsp_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } ctrl_state_type;

   // Capacity register as seen by the controller.
   typedef struct packed {
      logic             wr;
      logic [CNT_W-1:0] cap;
   } cfg_type;

   // Result word handed to the output queue.
   typedef struct packed {
      logic    valid;
      rsp_type word;
   } push_type;

   // Output queue room, registered and including a pop in this cycle.
   typedef struct packed {
      logic has_room;
      logic room_now;
   } oq_stat_type;

endpackage

// ===== sv/byte_ring_queue_overflow_clear.sv =====
// Channel    Direction  Handshake              Payload
// req_       in         req_valid/req_ready    brq_pkg::req_type (one word per operation)
// rsp_       out        rsp_valid/rsp_ready    brq_pkg::rsp_type (one word per result)
// APB        in/out     psel/penable/pready    capacity_in_use at byte address 0
//
// Write, clear and query words are accepted one per cycle while the output queue has room,
// so a write block streams in at one byte per cycle. A read of n bytes is accepted and then
// holds the input off until its last byte is queued, fetching one byte per cycle.
// Reset empties the queue and sets the capacity to 1024 (or DEPTH if smaller); the store
// itself is not cleared. Results pass through a two-word output queue, so a waiting result
// does not block the next input word; a stall on rsp_ready pauses a read run in place.
module byte_ring_queue_overflow_clear #(
   parameter int DEPTH    = 1024,
   parameter int MAX_READ = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brq_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   import brq_pkg::*;

   // The ring size saturates at the store depth, and at what the 11-bit field can hold.
   localparam logic [CNT_W-1:0] CAP_MAX = (DEPTH > 2047) ? 11'd2047 : CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_RST = (DEPTH > 1024) ? 11'd1024 : CNT_W'(DEPTH);

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic             cap_sel;
   logic             cap_wr;
   logic [CNT_W-1:0] wr_value;
   cfg_type          cfg;
   oq_stat_type      oq;
   push_type         push;

   // Register 0 sits at byte address 0; address 4 lies beyond the register list.
   assign cap_sel  = (paddr[2] == 1'b0);
   assign cap_wr   = psel && penable && pwrite && pready && cap_sel;
   assign wr_value = pwdata[CNT_W-1:0];
   assign pready   = 1'b1;
   assign prdata   = cap_sel ? {21'd0, cap_ff} : 32'd0;

   always_comb begin
      cap_in = cap_ff;
      if (cap_wr) begin
         cap_in = (wr_value > CAP_MAX) ? CAP_MAX : wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RST;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // A capacity write also empties the queue and drops any block in progress.
   assign cfg.wr  = cap_wr;
   assign cfg.cap = cap_ff;

   brq_ctrl #(
      .DEPTH    (DEPTH),
      .MAX_READ (MAX_READ)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .oq        (oq),
      .push      (push)
   );

   brq_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .stat      (oq),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/brq_ram.sv =====
module brq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // Read data holds until the next read.
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/brq_outq.sv =====
module brq_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  brq_pkg::push_type     push,
   output brq_pkg::oq_stat_type  stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output brq_pkg::rsp_type      rsp_data
);

   import brq_pkg::*;

   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] fill_ff, fill_in;
   logic       pop;

   assign rsp_valid     = (fill_ff != 2'd0);
   assign rsp_data      = slot0_ff;
   assign pop           = rsp_valid && rsp_ready;
   assign stat.has_room = (fill_ff != 2'd2);
   assign stat.room_now = (fill_ff != 2'd2) || rsp_ready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      fill_in  = fill_ff;
      if (pop && push.valid) begin
         if (fill_ff == 2'd1) begin
            slot0_in = push.word;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push.word;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         fill_in  = fill_ff - 2'd1;
      end else if (push.valid) begin
         if (fill_ff == 2'd0) begin
            slot0_in = push.word;
         end else begin
            slot1_in = push.word;
         end
         fill_in = fill_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== sv/brq_ctrl.sv =====
module brq_ctrl #(
   parameter int DEPTH    = 1024,
   parameter int MAX_READ = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  brq_pkg::req_type      req_data,
   input  brq_pkg::cfg_type      cfg,
   input  brq_pkg::oq_stat_type  oq,
   output brq_pkg::push_type     push
);

   import brq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [6:0] LIM_MAX = 7'(MAX_READ);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             acc_ff, acc_in;
   logic [1:0]       stat_ff, stat_in;
   logic [CNT_W-1:0] raddr_ff, raddr_in;
   logic [6:0]       left_ff, left_in;
   logic             pend_ff, pend_in;
   logic             pend_last_ff, pend_last_in;

   logic             accept;
   logic             start_read;
   logic             issue;
   logic             move;
   logic             wr_en;
   logic [CNT_W-1:0] wr_pos;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;
   logic [7:0]       rd_data;
   logic [31:0]      wr_pos_wide;
   logic [31:0]      rd_pos_wide;

   // Combinational helpers for the accepted word.
   logic [CNT_W-1:0] cap;
   logic [CNT_W-1:0] len;
   logic [CNT_W-1:0] free_space;
   logic [CNT_W:0]   sum;
   logic [CNT_W:0]   raddr_next;
   logic [6:0]       lim;
   logic [6:0]       n;
   logic             go;

   assign cap       = cfg.cap;
   assign len       = req_data.block_length;
   assign req_ready = (state_ff == S_IDLE) && oq.has_room;
   assign accept    = req_valid && req_ready;

   assign issue = (state_ff == S_READ) && (left_ff != 7'd0) && (!pend_ff || oq.room_now);
   assign move  = (state_ff == S_READ) && pend_ff && oq.room_now;

   assign lim = (req_data.read_limit > LIM_MAX) ? LIM_MAX : req_data.read_limit;
   assign n   = (cnt_ff < {4'd0, lim}) ? cnt_ff[6:0] : lim;
   assign start_read = accept && (req_data.op == OP_READ) && (cap != '0) && (n != 7'd0);

   assign raddr_next  = {1'b0, raddr_ff} + 12'd1;
   assign wr_pos_wide = 32'(wr_pos);
   assign rd_pos_wide = 32'(raddr_ff);
   assign wr_addr     = wr_pos_wide[AW-1:0];
   assign rd_addr     = rd_pos_wide[AW-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start_read) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (move && pend_last_ff) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rp_in        = rp_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      stat_in      = stat_ff;
      raddr_in     = raddr_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      push         = '0;
      wr_en        = 1'b0;
      wr_pos       = '0;
      go           = 1'b0;
      free_space   = cap - cnt_ff;
      sum          = '0;

      if (cfg.wr) begin
         rp_in   = '0;
         cnt_in  = '0;
         rem_in  = '0;
         acc_in  = 1'b0;
         stat_in = WS_OK;
      end else if (accept) begin
         unique case (req_data.op)
            OP_WRITE: begin
               if (req_data.block_first) begin
                  if (len == '0) begin
                     rem_in  = '0;
                     acc_in  = 1'b0;
                     stat_in = WS_OK;
                     push.valid             = 1'b1;
                     push.word.result_kind  = KIND_STATUS;
                     push.word.write_status = WS_OK;
                     push.word.used_count   = cnt_ff;
                  end else begin
                     if ((cap == '0) || (len > cap)) begin
                        acc_in  = 1'b0;
                        stat_in = WS_TOO_LARGE;
                     end else begin
                        acc_in  = 1'b1;
                        stat_in = WS_OK;
                        if (len > free_space) begin
                           rp_in   = '0;
                           cnt_in  = '0;
                           stat_in = WS_OVERFLOW;
                        end
                     end
                     rem_in = len;
                     go     = 1'b1;
                  end
               end else if (rem_ff != '0) begin
                  go = 1'b1;
               end
               if (go) begin
                  if (acc_in && (cap != '0) && (cnt_in < cap)) begin
                     sum    = {1'b0, rp_in} + {1'b0, cnt_in};
                     wr_pos = (sum >= {1'b0, cap}) ? CNT_W'(sum - {1'b0, cap})
                                                   : sum[CNT_W-1:0];
                     wr_en  = 1'b1;
                     cnt_in = cnt_in + 11'd1;
                  end
                  rem_in = rem_in - 11'd1;
                  if (rem_in == '0) begin
                     push.valid             = 1'b1;
                     push.word.result_kind  = KIND_STATUS;
                     push.word.write_status = stat_in;
                     push.word.used_count   = cnt_in;
                  end
               end
            end
            OP_READ: begin
               if (start_read) begin
                  sum      = {1'b0, rp_ff} + {5'd0, n};
                  rp_in    = (sum >= {1'b0, cap}) ? CNT_W'(sum - {1'b0, cap})
                                                  : sum[CNT_W-1:0];
                  cnt_in   = cnt_ff - {4'd0, n};
                  if (cnt_in == '0) begin
                     rp_in = '0;
                  end
                  raddr_in = rp_ff;
                  left_in  = n;
               end else begin
                  push.valid            = 1'b1;
                  push.word.result_kind = KIND_BYTE;
                  push.word.last        = 1'b1;
                  push.word.used_count  = cnt_ff;
               end
            end
            OP_CLEAR: begin
               rp_in  = '0;
               cnt_in = '0;
            end
            OP_QUERY: begin
               push.valid            = 1'b1;
               push.word.result_kind = KIND_COUNT;
               push.word.used_count  = cnt_ff;
            end
            default: ;
         endcase
      end

      // Read run: RAM data moves to the output queue while the next byte is fetched.
      if (move) begin
         push.valid            = 1'b1;
         push.word.result_kind = KIND_BYTE;
         push.word.read_byte   = rd_data;
         push.word.byte_valid  = 1'b1;
         push.word.last        = pend_last_ff;
         push.word.used_count  = cnt_ff;
         pend_in               = 1'b0;
      end
      if (issue) begin
         raddr_in     = (raddr_next >= {1'b0, cap}) ? '0 : raddr_next[CNT_W-1:0];
         left_in      = left_ff - 7'd1;
         pend_in      = 1'b1;
         pend_last_in = (left_ff == 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff     <= raddr_in;
      pend_last_ff <= pend_last_in;
      if (reset) begin
         state_ff <= S_IDLE;
         rp_ff    <= '0;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         acc_ff   <= 1'b0;
         stat_ff  <= WS_OK;
         left_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rp_ff    <= rp_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         acc_ff   <= acc_in;
         stat_ff  <= stat_in;
         left_ff  <= left_in;
         pend_ff  <= pend_in;
      end
   end

   brq_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.data_byte),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== bench/tb_byte_ring_queue_overflow_clear.sv =====
module tb_byte_ring_queue_overflow_clear;
   import brq_pkg::*;

   localparam int CLK_HALF      = 6;
   localparam int RING_MAX      = 1024;
   localparam int READ_MAX      = 64;
   localparam int CYCLE_LIMIT   = 400000;
   // After the last expected result, a read run or a write byte may still be in flight.
   // The settle time covers the longest read run, of MAX_READ bytes.
   localparam int SETTLE_CYCLES = 80;
   // Length of the long receiver stall that fills the output queue.
   localparam int HOLD_CYCLES   = 300;
   localparam logic [2:0] CAP_ADDR = 3'd0;

   // The tracker mirrors the queue: ring contents, head and fill level, the state of the
   // write block in progress and the ring size in use. Every accepted input word is
   // applied to it, and the result words it predicts wait in due_results in order.
   class byte_ring_tracker;
      logic [7:0]  ring_mem [RING_MAX];
      int unsigned head;
      int unsigned fill;
      int unsigned cap;
      int unsigned blk_left;
      bit          blk_taken;
      logic [1:0]  blk_status;
      rsp_type     due_results[$];
      int unsigned n_errors;

      function new();
         n_errors = 0;
         set_capacity(11'd1024);
      endfunction

      // A capacity write reinitializes the queue and abandons any open block.
      function void set_capacity(logic [10:0] value);
         cap        = (value > RING_MAX) ? RING_MAX : value;
         head       = 0;
         fill       = 0;
         blk_left   = 0;
         blk_taken  = 1'b0;
         blk_status = WS_OK;
      endfunction

      function void push_due(logic [1:0] kind, logic [1:0] status, logic [7:0] data,
                             logic valid, logic last);
         rsp_type r;
         r.result_kind  = kind;
         r.write_status = status;
         r.read_byte    = data;
         r.byte_valid   = valid;
         r.last         = last;
         r.used_count   = fill[10:0];
         due_results.push_back(r);
      endfunction

      function void note_word(req_type w);
         int unsigned lim;
         int unsigned n;
         int unsigned start;
         int unsigned free_space;
         case (w.op)
            OP_WRITE: begin
               if (w.block_first) begin
                  if (w.block_length == 0) begin
                     blk_left   = 0;
                     blk_taken  = 1'b0;
                     blk_status = WS_OK;
                     push_due(KIND_STATUS, WS_OK, 8'd0, 1'b0, 1'b0);
                     return;
                  end
                  if (cap == 0 || w.block_length > cap) begin
                     blk_taken  = 1'b0;
                     blk_status = WS_TOO_LARGE;
                  end else begin
                     free_space = (fill >= cap) ? 0 : cap - fill;
                     blk_taken  = 1'b1;
                     blk_status = WS_OK;
                     if (w.block_length > free_space) begin
                        head       = 0;
                        fill       = 0;
                        blk_status = WS_OVERFLOW;
                     end
                  end
                  blk_left = w.block_length;
               end else if (blk_left == 0) begin
                  return;
               end
               if (blk_taken && cap != 0 && fill < cap) begin
                  ring_mem[(head + fill) % cap] = w.data_byte;
                  fill++;
               end
               blk_left--;
               if (blk_left == 0)
                  push_due(KIND_STATUS, blk_status, 8'd0, 1'b0, 1'b0);
            end
            OP_READ: begin
               lim = (w.read_limit > READ_MAX) ? READ_MAX : w.read_limit;
               n   = (fill < lim) ? fill : lim;
               if (cap == 0 || n == 0) begin
                  push_due(KIND_BYTE, WS_OK, 8'd0, 1'b0, 1'b1);
                  return;
               end
               start = head % cap;
               head  = (start + n) % cap;
               fill  = fill - n;
               if (fill == 0)
                  head = 0;
               for (int i = 0; i < n; i++)
                  push_due(KIND_BYTE, WS_OK, ring_mem[(start + i) % cap], 1'b1, i == n - 1);
            end
            OP_CLEAR: begin
               head = 0;
               fill = 0;
            end
            default: begin
               push_due(KIND_COUNT, WS_OK, 8'd0, 1'b0, 1'b0);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [10:0] want, logic [10:0] got);
         if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            n_errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $error("result word %h arrived with nothing expected", got);
            n_errors++;
            return;
         end
         want = due_results.pop_front();
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("write_status", want.write_status, got.write_status);
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("byte_valid", want.byte_valid, got.byte_valid);
         compare_field("last", want.last, got.last);
         compare_field("used_count", want.used_count, got.used_count);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count   = 0;
   bit          hold_request  = 1'b0;
   byte_ring_tracker tracker;

   byte_ring_queue_overflow_clear DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("byte_ring_queue_overflow_clear verification failed");
         $finish;
      end
   end

   // Result words are sampled at the rising edge and checked against the oldest
   // prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_data);
   end

   // The receiver drives rsp_ready at the falling edge. Normally it stalls at random
   // with the current idle percentage. When the main process asks for it, the receiver
   // holds off for a long stretch so the two-word output queue fills and the block has
   // to stall its input while the sender keeps offering words.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready    = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // A word with every field random; the caller then sets the fields that matter.
   // The fields an operation ignores stay random so all their bits toggle too.
   function automatic req_type random_word(logic [1:0] op);
      req_type w;
      w    = req_type'($urandom);
      w.op = op;
      return w;
   endfunction

   // Offers one word, possibly after idling at random, and holds it until the block
   // takes it. Called and returns at a falling edge; valid stays high between
   // back-to-back words so the sender can stream at full rate.
   task automatic push_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      tracker.note_word(w);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [1:0] op);
      push_word(random_word(op));
   endtask

   task automatic send_read(input int limit);
      req_type w;
      w            = random_word(OP_READ);
      w.read_limit = limit[6:0];
      push_word(w);
   endtask

   // Sends nbytes write words of a block whose header announces hdr_len bytes. Fewer
   // bytes than announced leave the block open for the next header to abandon. A
   // negative data_value gives random data.
   task automatic send_block(input int hdr_len, input int nbytes, input int data_value);
      req_type w;
      for (int i = 0; i < nbytes; i++) begin
         w             = random_word(OP_WRITE);
         w.block_first = (i == 0);
         if (i == 0)
            w.block_length = hdr_len[10:0];
         if (data_value >= 0)
            w.data_byte = data_value[7:0];
         push_word(w);
      end
   endtask

   // A write byte with no header. Outside a block the block ignores it; inside an open
   // block it continues that block.
   task automatic send_stray();
      req_type w;
      w             = random_word(OP_WRITE);
      w.block_first = 1'b0;
      push_word(w);
   endtask

   // Drops valid and waits until every predicted result has arrived, then lets the
   // pipeline run dry before anything touches the capacity register.
   task automatic drain_results();
      req_valid = 1'b0;
      while (tracker.due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the edge where
   // psel, penable, pwrite and pready are all high.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      tracker.set_capacity(value[10:0]);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Mostly well-formed blocks with random content, mixed with reads, queries and
   // clears, and a share of broken traffic: blocks cut short, zero-length headers,
   // oversized headers and stray bytes. Block lengths stay small against the ring size,
   // with an occasional block exactly as long as the ring.
   task automatic random_traffic(input int word_budget);
      int unsigned pick;
      int unsigned len;
      int unsigned top;
      int unsigned lim_pick;
      int unsigned limit;
      int unsigned cut;
      int          spent;
      spent = 0;
      while (spent < word_budget) begin
         pick = $urandom_range(99);
         top  = (tracker.cap == 0) ? 6 : ((tracker.cap + 2 < 12) ? tracker.cap + 2 : 12);
         if (pick < 45) begin
            len = $urandom_range(top, 1);
            if (tracker.cap != 0 && tracker.cap <= READ_MAX && $urandom_range(9) == 0)
               len = tracker.cap;
            send_block(len, len, -1);
            spent += len;
         end else if (pick < 62) begin
            lim_pick = $urandom_range(9);
            limit = (lim_pick == 0) ? 0 :
                    (lim_pick == 1) ? $urandom_range(127, READ_MAX + 1) :
                    (lim_pick == 2) ? READ_MAX : $urandom_range(8, 1);
            send_read(limit);
            spent++;
         end else if (pick < 72) begin
            send_op(OP_QUERY);
            spent++;
         end else if (pick < 77) begin
            send_op(OP_CLEAR);
            spent++;
         end else if (pick < 87) begin
            len = $urandom_range(top + 1, 2);
            cut = $urandom_range(len - 1, 1);
            send_block(len, cut, -1);
            spent += cut;
         end else if (pick < 92) begin
            send_block(0, 1, -1);
            spent++;
         end else begin
            send_stray();
            spent++;
         end
      end
   endtask

   int unsigned cap_plan    [6] = '{4, 0, 37, 2047, 1, 1024};
   int          budget_plan [6] = '{14, 8, 14, 14, 10, 13};

   initial begin
      tracker   = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset capacity of 1024 bytes.
      send_idle_pct = 35;
      recv_idle_pct = 62;
      send_op(OP_QUERY);          // count of an empty queue
      send_read(5);               // empty queue gives the empty marker
      send_block(3, 3, 8'h00);    // data extremes
      send_block(2, 2, 8'hFF);
      send_block(0, 1, -1);       // zero-length block reports ok at once
      send_stray();               // byte outside a block is ignored
      send_op(OP_QUERY);
      send_read(0);               // zero limit gives the empty marker
      send_read(127);             // limit saturates, takes all five bytes
      send_block(2047, 1, -1);    // oversized header, left open ...
      send_block(2, 2, -1);       // ... and abandoned by the next block
      send_block(4, 2, -1);       // block cut short, its two bytes stay
      send_block(1, 1, -1);
      send_block(3, 1, -1);       // clear in the middle of a block: the rest of
      send_op(OP_CLEAR);          // the block is still stored afterward
      send_stray();
      send_stray();
      send_read(READ_MAX);

      // Phases over several ring sizes: a tiny ring that wraps and overflows often, an
      // invalid ring, a mid-size ring, an out-of-range value that saturates, a one-byte
      // ring and the full store. Idling moves from the sender-light mix to the
      // receiver-light mix and then to full rate.
      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 35 : (p < 4) ? 62 : 0;
         recv_idle_pct = (p < 2) ? 62 : (p < 4) ? 35 : 0;
         drain_results();
         csr_write(CAP_ADDR, cap_plan[p]);
         if (p == 4) begin
            // Long receiver stall while the sender keeps going.
            hold_request = 1'b1;
            repeat (12) send_op(OP_QUERY);
            send_block(1, 1, -1);
            send_read(READ_MAX);
         end
         random_traffic(budget_plan[p]);
      end

      drain_results();
      if (tracker.n_errors == 0)
         $display("byte_ring_queue_overflow_clear verification clean");
      else
         $display("byte_ring_queue_overflow_clear verification failed");
      $finish;
   end

endmodule
